@@ hw/rtl/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window maximum
// Sample type, window sizing and the structs passed along the cell chain.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int WINDOW_MAX   = 32;
  localparam int SAMPLE_WIDTH = 16;
  localparam int CFG_WIDTH    = 6;
  localparam int CNT_W        = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W        = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [CNT_W-1:0]               count_t;
  typedef logic [IDX_W-1:0]               index_t;

  // Shift codes applied to the whole candidate row in one update
  typedef enum logic [1:0] {
    SHIFT_NONE = 2'd0,
    SHIFT_ONE  = 2'd1,
    SHIFT_TWO  = 2'd2
  } shift_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic    accept;
    logic    new_set;
    sample_t sample;
    shift_t  shift;
  } cell_ctrl_t;

  // What a cell shows its neighbors: its content after the append step
  typedef struct packed {
    sample_t value;
    logic    valid;
    logic    keep;
  } cell_link_t;

endpackage

@@ hw/rtl/swm_if.sv @@
// ----------------------------------------------------------------------------
// swm_in_if / swm_out_if: valid/ready channels of the sliding window maximum
// Input carries one sample and a new-set flag, output one window maximum.
// ----------------------------------------------------------------------------
interface swm_in_if;
  import swm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    new_set;

  modport source (output valid, output sample, output new_set, input ready);
  modport sink   (input valid, input sample, input new_set, output ready);
endinterface

interface swm_out_if;
  import swm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t window_max;

  modport source (output valid, output window_max, input ready);
  modport sink   (input valid, input window_max, output ready);
endinterface

@@ hw/rtl/sliding_window_maximum.sv @@
// ----------------------------------------------------------------------------
// sliding_window_maximum: running maximum over the last window_size samples
// Candidate row of cells kept non-increasing front to back, plus a history
// shift line that supplies the sample leaving the window.
// ----------------------------------------------------------------------------
// Usage:
//   din  carries one signed sample per transaction and a new_set flag that
//        restarts the window before the sample is taken.
//   dout carries window_max, one transaction per input once the current set
//        has seen window_size samples; earlier inputs give no result.
//   cfg_we/cfg_data write window_size (1..32; 0 acts as 1, above 32 as 32).
//        Write it only while the block is idle.
// Timing:
//   A result appears on dout the cycle after its input transaction. The
//   block takes one sample per cycle unless dout stalls; each sample updates
//   the whole candidate row at once, so the row's compare and shift sets
//   the rate.
// Reset (rst, synchronous): empties the candidate row, clears the fill count
//   and the output valid flag, and sets window_size to 1.
// Stall: while a result waits on dout and the receiver holds ready low,
//   din.ready drops; it rises again in the cycle the result is taken.
// ----------------------------------------------------------------------------
module sliding_window_maximum (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [swm_pkg::CFG_WIDTH-1:0] cfg_data,
  swm_in_if.sink                       din,
  swm_out_if.source                    dout
);
  import swm_pkg::*;

  logic [CFG_WIDTH-1:0] window_size;
  count_t               fill;
  count_t               fill_base;
  count_t               fill_next;
  count_t               eff_size;
  index_t               back;
  logic                 accept;
  logic                 emit;
  logic                 full_shift;
  logic                 drop;
  sample_t              front;
  sample_t              oldest;
  logic                 out_valid;
  sample_t              window_max;
  cell_ctrl_t           ctrl;
  cell_link_t           links [WINDOW_MAX + 2];

  assign accept    = din.valid && din.ready;
  assign din.ready = !out_valid || dout.ready;

  // Clamp the window size into 1..WINDOW_MAX
  always_comb begin
    if (window_size == '0) begin
      eff_size = count_t'(1);
    end else if (CNT_W'(window_size) > count_t'(WINDOW_MAX)) begin
      eff_size = count_t'(WINDOW_MAX);
    end else begin
      eff_size = CNT_W'(window_size);
    end
  end
  assign back = IDX_W'(eff_size - count_t'(1));

  // Fill count restarts with a new set and saturates at the window limit
  assign fill_base = din.new_set ? '0 : fill;
  assign fill_next = (fill_base == count_t'(WINDOW_MAX)) ? fill_base
                                                         : fill_base + count_t'(1);
  assign emit      = fill_next >= eff_size;

  // Row full and every entry kept: drop the front to make room
  assign full_shift = links[WINDOW_MAX - 1].keep;
  assign front      = full_shift ? links[1].value : links[0].value;
  // Retire the front when it is the sample leaving the window
  assign drop       = emit && (front == oldest);

  always_comb begin
    ctrl.accept  = accept;
    ctrl.new_set = din.new_set;
    ctrl.sample  = din.sample;
    case ({full_shift, drop})
      2'b00:   ctrl.shift = SHIFT_NONE;
      2'b11:   ctrl.shift = SHIFT_TWO;
      default: ctrl.shift = SHIFT_ONE;
    endcase
  end

  // Virtual entries past the end: the appended sample when the row overflows
  assign links[WINDOW_MAX].value     = din.sample;
  assign links[WINDOW_MAX].valid     = links[WINDOW_MAX - 1].keep;
  assign links[WINDOW_MAX].keep      = 1'b0;
  assign links[WINDOW_MAX + 1].value = din.sample;
  assign links[WINDOW_MAX + 1].valid = 1'b0;
  assign links[WINDOW_MAX + 1].keep  = 1'b0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic prev_keep;
    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
    end else begin : g_body
      assign prev_keep = links[i-1].keep;
    end
    swm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .prev_keep (prev_keep),
      .up1       (links[i+1]),
      .up2       (links[i+2]),
      .link      (links[i])
    );
  end

  swm_hist u_hist (
    .clk    (clk),
    .accept (accept),
    .sample (din.sample),
    .back   (back),
    .oldest (oldest)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= CFG_WIDTH'(1);
      fill        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_size <= cfg_data;
      end
      if (accept) begin
        fill <= fill_next;
      end
      // Hold a result until taken; load a new one on each emitting transaction
      if (accept && emit) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      window_max <= front;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.window_max = window_max;

endmodule

@@ hw/rtl/swm_cell.sv @@
// ----------------------------------------------------------------------------
// swm_cell: one entry of the candidate row
// Holds one candidate, drops it when beaten by a new sample, takes the new
// sample at the append point and shifts toward the front by zero to two.
// ----------------------------------------------------------------------------
module swm_cell (
  input  logic                clk,
  input  logic                rst,
  input  swm_pkg::cell_ctrl_t ctrl,
  input  logic                prev_keep,
  input  swm_pkg::cell_link_t up1,
  input  swm_pkg::cell_link_t up2,
  output swm_pkg::cell_link_t link
);
  import swm_pkg::*;

  sample_t value;
  logic    valid;
  logic    keep;

  // Keep an entry that is valid in this set and not below the new sample
  assign keep       = valid && !ctrl.new_set && (value >= ctrl.sample);
  assign link.keep  = keep;
  assign link.valid = keep || prev_keep;
  assign link.value = keep ? value : ctrl.sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.accept) begin
      case (ctrl.shift)
        SHIFT_NONE: valid <= link.valid;
        SHIFT_ONE:  valid <= up1.valid;
        SHIFT_TWO:  valid <= up2.valid;
        default:    valid <= link.valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      case (ctrl.shift)
        SHIFT_NONE: value <= link.value;
        SHIFT_ONE:  value <= up1.value;
        SHIFT_TWO:  value <= up2.value;
        default:    value <= link.value;
      endcase
    end
  end

endmodule

@@ hw/rtl/swm_hist.sv @@
// ----------------------------------------------------------------------------
// swm_hist: history shift line
// Holds the most recent samples and returns the one leaving the window.
// ----------------------------------------------------------------------------
module swm_hist (
  input  logic             clk,
  input  logic             accept,
  input  swm_pkg::sample_t sample,
  input  swm_pkg::index_t  back,
  output swm_pkg::sample_t oldest
);
  import swm_pkg::*;

  localparam int DEPTH = (WINDOW_MAX > 1) ? WINDOW_MAX - 1 : 1;

  sample_t taps [DEPTH];
  index_t  sel;

  // taps[j] holds the sample j+1 transactions back
  always_ff @(posedge clk) begin
    if (accept) begin
      taps[0] <= sample;
      for (int j = 1; j < DEPTH; j++) begin
        taps[j] <= taps[j-1];
      end
    end
  end

  assign sel    = back - index_t'(1);
  assign oldest = (back == '0) ? sample : taps[sel];

endmodule

@@ tb/sliding_window_maximum_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_maximum_tb: self-checking bench for the sliding window maximum
// Streams signed samples through the block under several window sizes and
// compares every window_max against a cycle-free model of the candidate row.
// ----------------------------------------------------------------------------
module sliding_window_maximum_tb;
  import swm_pkg::*;

  localparam sample_t SAMPLE_TOP    = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_BOTTOM = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam int      RANDOM_ITEMS  = 1550;
  localparam int      SETTLE_CYCLES = 4;   // result lands in the cycle after its input

  // Shape of the samples within one set
  typedef enum int {
    STYLE_WIDE,
    STYLE_NARROW,
    STYLE_FALLING,
    STYLE_RISING,
    STYLE_CORNER
  } style_t;

  // How the receiver throttles dout.ready
  typedef enum int {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PULSE
  } rx_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the candidate row, history ring and fill count, and
  // queues the window maximum that each accepted sample should produce.
  // --------------------------------------------------------------------------
  class window_max_board;
    sample_t                 candidates [WINDOW_MAX];
    int                      cand_depth;
    sample_t                 history [WINDOW_MAX];
    int                      next_slot;
    int                      seen;
    logic [CFG_WIDTH-1:0]    window;
    sample_t                 expected_maxima [$];
    int                      failures;

    function new();
      cand_depth = 0;
      next_slot  = 0;
      seen       = 0;
      window     = 1;
      failures   = 0;
    endfunction

    function void set_window(logic [CFG_WIDTH-1:0] size);
      window = size;
    endfunction

    function int pending();
      return expected_maxima.size();
    endfunction

    function void drop_head();
      if (cand_depth == 0) return;
      for (int i = 0; i < cand_depth - 1; i++) candidates[i] = candidates[i+1];
      cand_depth--;
    endfunction

    // Advance the model by one accepted sample
    function void note_sample(sample_t value, logic start_set);
      int      span;
      int      oldest;
      sample_t front;
      span = (window == 0) ? 1 : (window > WINDOW_MAX) ? WINDOW_MAX : int'(window);
      if (start_set) begin
        cand_depth = 0;
        seen       = 0;
        next_slot  = 0;
      end
      while (cand_depth > 0 && candidates[cand_depth-1] < value) cand_depth--;
      if (cand_depth >= WINDOW_MAX) drop_head();
      candidates[cand_depth] = value;
      cand_depth++;
      history[next_slot] = value;
      oldest    = (next_slot + WINDOW_MAX - (span - 1)) % WINDOW_MAX;
      next_slot = (next_slot + 1) % WINDOW_MAX;
      if (seen < WINDOW_MAX) seen++;
      if (seen < span) return;
      front = candidates[0];
      expected_maxima.insert(expected_maxima.size(), front);
      if (front == history[oldest]) drop_head();
    endfunction

    function void check_max(sample_t got);
      sample_t want;
      if (expected_maxima.size() == 0) begin
        failures++;
        if (failures <= 20)
          $display("%0t: window_max mismatch: expected none, got %0d", $time, got);
        return;
      end
      want = expected_maxima[0];
      expected_maxima.delete(0);
      if (got !== want) begin
        failures++;
        if (failures <= 20)
          $display("%0t: window_max mismatch: expected %0d, got %0d", $time, want, got);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_WIDTH-1:0] cfg_data;

  swm_in_if  din_if ();
  swm_out_if dout_if ();

  window_max_board sb = new();

  always #5 clk = ~clk;

  sliding_window_maximum u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .din      (din_if),
    .dout     (dout_if)
  );

  // --------------------------------------------------------------------------
  // Receiver: hold ready according to a mode that is redrawn at random,
  // so stalls land on every phase of the sample stream.
  // --------------------------------------------------------------------------
  int       rx_cycle = 0;
  rx_mode_t rx_mode  = RX_OPEN;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 128 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:  dout_if.ready <= 1'b1;
      RX_LIGHT: dout_if.ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: dout_if.ready <= ($urandom_range(0, 7) == 0);
      default:  dout_if.ready <= rx_cycle[2];
    endcase
  end

  // --------------------------------------------------------------------------
  // Monitor: settle the output transaction first, since it always belongs to
  // an older input than one accepted at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (dout_if.valid && dout_if.ready) sb.check_max(dout_if.window_max);
      if (din_if.valid && din_if.ready) sb.note_sample(din_if.sample, din_if.new_set);
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  int      burst_left = 0;
  bit      no_gaps    = 1'b0;
  int      items_sent = 0;
  sample_t last_value = '0;

  // Present one sample and hold it until the transaction completes
  task automatic send_item(input sample_t value, input logic start_set);
    din_if.valid   <= 1'b1;
    din_if.sample  <= value;
    din_if.new_set <= start_set;
    do @(posedge clk); while (!din_if.ready);
  endtask

  // Between bursts, drop valid for a random gap; in steady phases keep streaming
  task automatic pace();
    int gap;
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 24);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      din_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected maximum has been taken; the
  // extra cycles cover a last input that produced no result yet
  task automatic wait_idle();
    din_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write window_size; only called while the block is idle
  task automatic write_window(input logic [CFG_WIDTH-1:0] size);
    cfg_we   <= 1'b1;
    cfg_data <= size;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.set_window(size);
  endtask

  function automatic sample_t next_sample(style_t style, sample_t prev);
    case (style)
      STYLE_WIDE:    return sample_t'($urandom);
      STYLE_NARROW:  return sample_t'(int'($urandom_range(0, 6)) - 3);
      STYLE_FALLING: return prev - sample_t'($urandom_range(0, 3));
      STYLE_RISING:  return prev + sample_t'($urandom_range(0, 3));
      default: begin
        case ($urandom_range(0, 3))
          0:       return SAMPLE_TOP;
          1:       return SAMPLE_BOTTOM;
          2:       return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // One phase of random samples. keep_set continues the current set across a
  // window change; set_odds gives the chance (1 in N) of a fresh set mid-run,
  // 0 for none.
  task automatic run_phase(input int count, input bit keep_set, input style_t first_style,
                           input int set_odds);
    style_t  style;
    sample_t value;
    logic    start;
    style = first_style;
    for (int i = 0; i < count; i++) begin
      if (i == 0) start = !keep_set;
      else start = (set_odds != 0) && ($urandom_range(1, set_odds) == 1);
      if (start && i != 0) style = style_t'($urandom_range(0, 4));
      value = next_sample(style, last_value);
      send_item(value, start);
      last_value = value;
      items_sent++;
      pace();
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [CFG_WIDTH-1:0] size;
    int                   pick;

    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_data       <= '0;
    din_if.valid   <= 1'b0;
    din_if.sample  <= '0;
    din_if.new_set <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Window of one after reset: every sample is its own maximum, extremes first
    send_item(SAMPLE_TOP, 1'b1);
    send_item(SAMPLE_BOTTOM, 1'b0);
    send_item('0, 1'b0);
    send_item('1, 1'b0);
    wait_idle();

    // Window of three: equal values, a new peak, and the peak ageing out
    write_window(6'd3);
    send_item(sample_t'(4), 1'b1);   // window not yet full
    send_item(sample_t'(4), 1'b0);
    send_item(sample_t'(4), 1'b0);   // duplicates stay, front leaves once
    send_item(sample_t'(2), 1'b0);
    send_item(sample_t'(9), 1'b0);
    send_item(sample_t'(1), 1'b0);
    send_item(sample_t'(0), 1'b0);
    send_item(sample_t'(-5), 1'b0);  // the 9 has left the window
    send_item(sample_t'(7), 1'b1);   // fresh set: no result until full again
    send_item(sample_t'(8), 1'b0);
    send_item(sample_t'(6), 1'b0);
    wait_idle();

    // Size zero acts as one
    write_window('0);
    send_item(sample_t'(-3), 1'b1);
    send_item(sample_t'(100), 1'b0);
    wait_idle();

    // Full-size window with a falling run, then shrink within the same set so
    // the candidate row overflows and must discard its front
    write_window(6'd32);
    no_gaps = 1'b0;
    last_value = SAMPLE_TOP;
    run_phase(40, 1'b0, STYLE_FALLING, 0);
    write_window(6'd2);
    run_phase(40, 1'b1, STYLE_FALLING, 0);

    // Largest register value, clamped to the full window
    write_window('1);
    run_phase(70, 1'b0, STYLE_WIDE, 0);

    // Random phases: a new size each time, sometimes carrying the set over
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       size = '0;
        1:       size = CFG_WIDTH'($urandom_range(WINDOW_MAX + 1, 63));
        2:       size = CFG_WIDTH'(WINDOW_MAX);
        3, 4:    size = CFG_WIDTH'($urandom_range(9, WINDOW_MAX - 1));
        default: size = CFG_WIDTH'($urandom_range(1, 8));
      endcase
      write_window(size);
      no_gaps = ($urandom_range(0, 3) == 0);
      run_phase($urandom_range(20, 100), ($urandom_range(0, 3) == 0),
                style_t'($urandom_range(0, 4)), 16);
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/swm_pkg.sv
hw/rtl/swm_if.sv
hw/rtl/swm_cell.sv
hw/rtl/swm_hist.sv
hw/rtl/sliding_window_maximum.sv
tb/sliding_window_maximum_tb.sv
